@@ sv/mcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpq_pkg
// shared types and default sizes for the multi-class priority queue
// ----------------------------------------------------------------------------
package mcpq_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int TICKET_BITS_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int QUEUES_DEF        = 3;

    localparam int KIND_W = 2;
    localparam int QSEL_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // per-queue command strobes for one apply cycle
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } chain_ctrl_t;

endpackage

@@ sv/mcpq_cell.sv @@
// ----------------------------------------------------------------------------
// mcpq_cell
// one slot of a sorted shift chain: keeps, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module mcpq_cell #(
    parameter int TICKET_BITS   = mcpq_pkg::TICKET_BITS_DEF,
    parameter int PRIORITY_BITS = mcpq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                     clk,
    input  mcpq_pkg::chain_ctrl_t    ctrl,
    input  logic                     occupied,
    input  logic                     ge_prev,
    output logic                     ge_out,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [TICKET_BITS-1:0]   new_ticket,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic [TICKET_BITS-1:0]   prev_ticket,
    input  logic [PRIORITY_BITS-1:0] nxt_prio,
    input  logic [TICKET_BITS-1:0]   nxt_ticket,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [TICKET_BITS-1:0]   ticket
);

    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic [TICKET_BITS-1:0]   ticket_reg;
    logic [TICKET_BITS-1:0]   ticket_next;

    // equal priority stays ahead of the newcomer, which keeps arrival order
    assign ge_out = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        prio_next   = prio_reg;
        ticket_next = ticket_reg;
        if (ctrl.ins && !ge_out)
        begin
            if (ge_prev)
            begin
                prio_next   = new_prio;
                ticket_next = new_ticket;
            end
            else
            begin
                prio_next   = prev_prio;
                ticket_next = prev_ticket;
            end
        end
        else if (ctrl.rem)
        begin
            prio_next   = nxt_prio;
            ticket_next = nxt_ticket;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg   <= prio_next;
        ticket_reg <= ticket_next;
    end

    assign prio   = prio_reg;
    assign ticket = ticket_reg;

endmodule

@@ sv/mcpq_chain.sv @@
// ----------------------------------------------------------------------------
// mcpq_chain
// one priority queue: a row of cells kept sorted, best entry at the head
// ----------------------------------------------------------------------------
module mcpq_chain #(
    parameter int CAPACITY      = mcpq_pkg::CAPACITY_DEF,
    parameter int TICKET_BITS   = mcpq_pkg::TICKET_BITS_DEF,
    parameter int PRIORITY_BITS = mcpq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mcpq_pkg::chain_ctrl_t    ctrl,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [TICKET_BITS-1:0]   new_ticket,
    output logic [TICKET_BITS-1:0]   head_ticket,
    output logic                     empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     full;
    mcpq_pkg::chain_ctrl_t    cell_ctrl;

    logic [PRIORITY_BITS-1:0] prio_q   [CAPACITY];
    logic [TICKET_BITS-1:0]   ticket_q [CAPACITY];
    logic                     ge       [CAPACITY];

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // inserts into a full queue are dropped, removes from an empty queue are ignored
    always_comb
    begin
        cell_ctrl     = ctrl;
        cell_ctrl.ins = ctrl.ins && !full;
        cell_ctrl.rem = ctrl.rem && !empty;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
            count_next = '0;
        else if (cell_ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cell_ctrl.rem)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     ge_left;
            logic [PRIORITY_BITS-1:0] left_prio;
            logic [TICKET_BITS-1:0]   left_ticket;
            logic [PRIORITY_BITS-1:0] right_prio;
            logic [TICKET_BITS-1:0]   right_ticket;

            if (i == 0)
            begin : g_first
                assign ge_left     = 1'b1;
                assign left_prio   = new_prio;
                assign left_ticket = new_ticket;
            end
            else
            begin : g_mid
                assign ge_left     = ge[i-1];
                assign left_prio   = prio_q[i-1];
                assign left_ticket = ticket_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_prio   = '0;
                assign right_ticket = '0;
            end
            else
            begin : g_inner
                assign right_prio   = prio_q[i+1];
                assign right_ticket = ticket_q[i+1];
            end

            mcpq_cell #(
                .TICKET_BITS   (TICKET_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .occupied    (CNT_W'(i) < count_reg),
                .ge_prev     (ge_left),
                .ge_out      (ge[i]),
                .new_prio    (new_prio),
                .new_ticket  (new_ticket),
                .prev_prio   (left_prio),
                .prev_ticket (left_ticket),
                .nxt_prio    (right_prio),
                .nxt_ticket  (right_ticket),
                .prio        (prio_q[i]),
                .ticket      (ticket_q[i])
            );
        end
    endgenerate

    assign head_ticket = ticket_q[0];

endmodule

@@ sv/multi_class_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// multi_class_priority_queue_top
// several priority queues with first-come order among equal priorities,
// sharing one saturating arrival ticket counter
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  command   start busy kind queue_sel priority_req  start && !busy
//  result    result_valid is_empty ticket            result_valid (no stall)
//
//  every command is first registered, then applied to the
//  cell chains; busy is high during the update cycle
//  a remove to a queue that exists shows its result in the cycle after
//  the update, for one cycle, while the next command may already be taken
//  asynchronous reset empties all queues and zeroes the ticket counter
// ----------------------------------------------------------------------------
module multi_class_priority_queue_top #(
    parameter int CAPACITY      = mcpq_pkg::CAPACITY_DEF,
    parameter int TICKET_BITS   = mcpq_pkg::TICKET_BITS_DEF,
    parameter int PRIORITY_BITS = mcpq_pkg::PRIORITY_BITS_DEF,
    parameter int QUEUES        = mcpq_pkg::QUEUES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mcpq_pkg::KIND_W-1:0] kind,
    input  logic [mcpq_pkg::QSEL_W-1:0] queue_sel,
    input  logic [PRIORITY_BITS-1:0]    priority_req,
    output logic                        result_valid,
    output logic                        is_empty,
    output logic [TICKET_BITS-1:0]      ticket
);

    logic                        busy_reg;
    logic                        busy_next;
    mcpq_pkg::kind_t             cmd_kind_reg;
    mcpq_pkg::kind_t             cmd_kind_next;
    logic [mcpq_pkg::QSEL_W-1:0] cmd_q_reg;
    logic [mcpq_pkg::QSEL_W-1:0] cmd_q_next;
    logic [PRIORITY_BITS-1:0]    cmd_prio_reg;
    logic [PRIORITY_BITS-1:0]    cmd_prio_next;
    logic [TICKET_BITS-1:0]      next_ticket_reg;
    logic [TICKET_BITS-1:0]      next_ticket_next;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    logic                        is_empty_reg;
    logic                        is_empty_next;
    logic [TICKET_BITS-1:0]      ticket_reg;
    logic [TICKET_BITS-1:0]      ticket_next;

    logic                        accept;
    logic                        q_ok;
    logic                        do_ins;
    logic                        do_rem;
    logic                        do_clr;
    logic [TICKET_BITS-1:0]      new_ticket;
    logic                        sel_empty;
    logic [TICKET_BITS-1:0]      sel_ticket;

    mcpq_pkg::chain_ctrl_t       ctrl     [QUEUES];
    logic [TICKET_BITS-1:0]      head_tk  [QUEUES];
    logic                        q_empty  [QUEUES];

    assign accept = start && !busy_reg;
    assign q_ok   = (int'(cmd_q_reg) < QUEUES);

    always_comb
    begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_clr = 1'b0;
        if (busy_reg)
        begin
            case (cmd_kind_reg)
                mcpq_pkg::KIND_INSERT: do_ins = 1'b1;
                mcpq_pkg::KIND_REMOVE: do_rem = 1'b1;
                mcpq_pkg::KIND_CLEAR:  do_clr = 1'b1;
                default:               ;
            endcase
        end
    end

    // ticket counter sticks at all ones
    assign new_ticket = (next_ticket_reg == '1) ? next_ticket_reg
                                                : next_ticket_reg + TICKET_BITS'(1);

    always_comb
    begin
        busy_next     = accept;
        cmd_kind_next = cmd_kind_reg;
        cmd_q_next    = cmd_q_reg;
        cmd_prio_next = cmd_prio_reg;
        if (accept)
        begin
            cmd_kind_next = mcpq_pkg::kind_t'(kind);
            cmd_q_next    = queue_sel;
            cmd_prio_next = priority_req;
        end
    end

    always_comb
    begin
        next_ticket_next = next_ticket_reg;
        if (do_clr)
            next_ticket_next = '0;
        else if (do_ins)
            next_ticket_next = new_ticket;
    end

    always_comb
    begin
        sel_empty  = 1'b1;
        sel_ticket = '0;
        for (int k = 0; k < QUEUES; k++)
        begin
            if (int'(cmd_q_reg) == k)
            begin
                sel_empty  = q_empty[k];
                sel_ticket = head_tk[k];
            end
        end
    end

    always_comb
    begin
        result_valid_next = do_rem && q_ok;
        is_empty_next     = sel_empty;
        ticket_next       = sel_empty ? '0 : sel_ticket;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            next_ticket_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            next_ticket_reg  <= next_ticket_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_kind_reg <= cmd_kind_next;
        cmd_q_reg    <= cmd_q_next;
        cmd_prio_reg <= cmd_prio_next;
        is_empty_reg <= is_empty_next;
        ticket_reg   <= ticket_next;
    end

    genvar g;
    generate
        for (g = 0; g < QUEUES; g++)
        begin : g_queue
            always_comb
            begin
                ctrl[g].ins = do_ins && (int'(cmd_q_reg) == g);
                ctrl[g].rem = do_rem && (int'(cmd_q_reg) == g);
                ctrl[g].clr = do_clr;
            end

            mcpq_chain #(
                .CAPACITY      (CAPACITY),
                .TICKET_BITS   (TICKET_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_chain (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl[g]),
                .new_prio    (cmd_prio_reg),
                .new_ticket  (new_ticket),
                .head_ticket (head_tk[g]),
                .empty       (q_empty[g])
            );
        end
    endgenerate

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign is_empty     = is_empty_reg;
    assign ticket       = ticket_reg;

endmodule

@@ sv/mcpq_checker.sv @@
// ----------------------------------------------------------------------------
// mcpq_checker
// port-level timing checks for the multi-class priority queue
// ----------------------------------------------------------------------------
module mcpq_checker #(
    parameter int TICKET_BITS = mcpq_pkg::TICKET_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [mcpq_pkg::KIND_W-1:0] kind,
    input logic                        result_valid,
    input logic                        is_empty,
    input logic [TICKET_BITS-1:0]      ticket
);

    // a command occupies exactly one update cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // results only come from an earlier remove, via the command and result registers
    a_result_from_remove: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(start && !busy, 2)
                          && ($past(kind, 2) == mcpq_pkg::KIND_REMOVE)))
        else $error("result without a matching remove");

    a_empty_zero_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_empty) |-> (ticket == '0))
        else $error("empty result carries a nonzero ticket");

endmodule

bind multi_class_priority_queue_top mcpq_checker #(
    .TICKET_BITS (TICKET_BITS)
) u_mcpq_checker (.*);
